// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros shared by the arcball tracker rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AQT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define AQT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aqt_pkg.sv =====
// ---------------------------------------------------------------------------
// aqt_pkg
// constants, types and rounding helpers of the arcball quaternion tracker
// ---------------------------------------------------------------------------
package aqt_pkg;

  // fixed point format of points and quaternions
  localparam int FRAC_BITS = 14;
  localparam int FW        = 16;
  localparam int CW        = 12;

  // datapath widths
  localparam int ACC_W  = 56;
  localparam int MUL_W  = 27;
  localparam int PROD_W = 2 * MUL_W;

  // shared divide / square root unit
  localparam int ISU_NUM_W  = 58;
  localparam int ISU_DEN_W  = 30;
  localparam int ISU_RES_W  = 29;
  localparam int ISU_REM_W  = 47;
  localparam int QUO_W      = 17;
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = ISU_NUM_W / 2;
  localparam int CNT_W      = 5;

  localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(1) <<< FRAC_BITS;
  localparam logic [ACC_W-1:0]        ONE_SQ  = ACC_W'(1) << (2 * FRAC_BITS);
  localparam logic [FW-1:0]           ONE_FW  = FW'(1 << FRAC_BITS);

  // |cross| > 0.0001 is len2 * 10^8 > 2^(2*frac), i.e. len2 above this bound
  localparam longint SMALL_AXIS_LIM = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;

  // register reset values and indexes
  localparam logic [CW-1:0] WIDTH_RST  = CW'(800);
  localparam logic [CW-1:0] HEIGHT_RST = CW'(600);
  localparam logic          CFG_WIDTH  = 1'b0;
  localparam logic          CFG_HEIGHT = 1'b1;

  // event codes
  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_MOVE    = 2'd2;
  localparam logic [2:0] BTN_LEFT    = 3'd0;

  typedef enum logic {ISU_DIV, ISU_SQRT} isu_op_t;

  typedef struct packed {
    logic    start;
    isu_op_t op;
  } isu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } isu_sts_t;

  // accumulator action applied in the cycle after the product is registered
  typedef enum logic [1:0] {M_NONE, M_LOAD, M_ADD, M_SUB} mop_t;

  // hamilton product schedule: delta index, orientation index, accumulate op
  localparam logic [1:0] QP_DI [16] = '{0, 1, 2, 3, 0, 1, 2, 3,
                                        0, 1, 2, 3, 0, 1, 2, 3};
  localparam logic [1:0] QP_QI [16] = '{0, 1, 2, 3, 1, 0, 3, 2,
                                        2, 3, 0, 1, 3, 2, 1, 0};
  localparam mop_t QP_OP [16] = '{M_LOAD, M_SUB, M_SUB, M_SUB,
                                  M_LOAD, M_ADD, M_ADD, M_SUB,
                                  M_LOAD, M_SUB, M_ADD, M_ADD,
                                  M_LOAD, M_ADD, M_SUB, M_ADD};

  // divide by 2^frac, nearest, halves away from zero
  function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] r;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    r   = (mag + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[ACC_W-1] ? -$signed(r) : $signed(r);
  endfunction

  // saturate to 16-bit signed
  function automatic logic [FW-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic [FW-1:0] r;
    if (v > 56'sd32767) r = 16'h7fff;
    else if (v < -56'sd32768) r = 16'h8000;
    else r = v[FW-1:0];
    return r;
  endfunction

  // apply sign to a magnitude and saturate to 16-bit signed
  function automatic logic [FW-1:0] sgn_sat(input logic [QUO_W-1:0] mag, input logic neg);
    logic [QUO_W-1:0] t;
    logic [FW-1:0]    r;
    t = -mag;
    if (!neg) r = (mag > 17'd32767) ? 16'h7fff : mag[FW-1:0];
    else r = (mag > 17'd32768) ? 16'h8000 : t[FW-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/arcball_quaternion_tracker_core.sv =====
// one event at a time: a release or an ignored event goes straight to the
// result word, a left press or a move while dragging runs the arcball steps
// on the shared divide/square-root unit, plus one multiply a cycle on the
// shared multiplier
// reset (rst_n, synchronous, active low): identity orientation, no drag,
// zero last point, screen 800 x 600
// ---------------------------------------------------------------------------
// arcball_quaternion_tracker_core
// pointer events drive an arcball orientation quaternion in s1.14
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module arcball_quaternion_tracker_core import aqt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [2:0]           in_button,
  input  logic signed [CW-1:0] in_pointer_x,
  input  logic signed [CW-1:0] in_pointer_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [FW-1:0] out_orient_w,
  output logic signed [FW-1:0] out_orient_x,
  output logic signed [FW-1:0] out_orient_y,
  output logic signed [FW-1:0] out_orient_z,
  output logic                 out_is_dragging,
  input  logic                 cfg_we,
  input  logic                 cfg_idx,
  input  logic [CW-1:0]        cfg_wdata
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_CMP,
    ST_NXS, ST_NXW, ST_NYS, ST_NYW, ST_Q1, ST_Q2, ST_Q3, ST_ZS, ST_ZW,
    ST_NORM, ST_O1, ST_O2, ST_O3, ST_OSQ, ST_OSQW, ST_MXS, ST_MXW, ST_MYS, ST_MYW,
    ST_PT, ST_D1, ST_D2, ST_D3, ST_X1, ST_X2, ST_Y1, ST_Y2, ST_Z1, ST_Z2,
    ST_L1, ST_L2, ST_L3, ST_QP, ST_F1, ST_COMMIT, ST_DONE
  } state_t;

  state_t                    state_r;
  logic [CW-1:0]             cfg_w_r;
  logic [CW-1:0]             cfg_h_r;
  logic                      drag_r;
  logic                      press_r;
  logic signed [13:0]        nxn_r;
  logic signed [13:0]        nyn_r;
  logic signed [25:0]        a_r;
  logic signed [25:0]        b_r;
  logic [24:0]               wh_r;
  logic [25:0]               ma_r;
  logic [25:0]               mb_r;
  logic [ISU_RES_W-1:0]      len_r;
  logic [FW-1:0]             nx_r;
  logic [FW-1:0]             ny_r;
  logic [2:0][FW-1:0]        c_r;
  logic [2:0][FW-1:0]        l_r;
  logic [3:0][FW-1:0]        d_r;
  logic [2:0][FW-1:0]        n_r;
  logic [3:0][FW-1:0]        q_r;
  logic [31:0]               len2_r;
  logic [3:0]                qp_cnt_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  mop_t                      mop_r;
  logic                      out_valid_r;
  logic [3:0][FW-1:0]        out_q_r;
  logic                      out_drag_r;

  logic [CW-1:0]             w_eff;
  logic [CW-1:0]             h_eff;
  logic signed [13:0]        nxn_in;
  logic signed [13:0]        nyn_in;
  logic [13:0]               nxn_mag;
  logic [13:0]               nyn_mag;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  mop_t                      mop;
  logic signed [ACC_W-1:0]   zv;
  logic signed [ACC_W-1:0]   rnd;
  logic [QUO_W-1:0]          zr;
  isu_ctl_t                  isu_ctl;
  isu_sts_t                  isu_sts;
  logic [ISU_NUM_W-1:0]      isu_num;
  logic [ISU_DEN_W-1:0]      isu_den;
  logic [ISU_RES_W-1:0]      isu_res;
  logic [ISU_REM_W-1:0]      isu_rem;

  function automatic logic signed [MUL_W-1:0] sx16(input logic [FW-1:0] v);
    return $signed({{(MUL_W-FW){v[FW-1]}}, v});
  endfunction

  // zero-sized window is taken as one pixel
  assign w_eff   = (cfg_w_r == '0) ? CW'(1) : cfg_w_r;
  assign h_eff   = (cfg_h_r == '0) ? CW'(1) : cfg_h_r;
  assign nxn_in  = $signed({in_pointer_x[CW-1], in_pointer_x, 1'b0}) - $signed({2'b00, w_eff});
  assign nyn_in  = $signed({2'b00, h_eff}) - $signed({in_pointer_y[CW-1], in_pointer_y, 1'b0});
  assign nxn_mag = nxn_r[13] ? 14'(-nxn_r) : 14'(nxn_r);
  assign nyn_mag = nyn_r[13] ? 14'(-nyn_r) : 14'(nyn_r);
  assign zv      = $signed(ONE_SQ) - acc_r;
  assign rnd     = rnd_shift(acc_r);
  assign zr      = isu_res[QUO_W-1:0] + QUO_W'(isu_rem > ISU_REM_W'(isu_res));

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mop   = M_NONE;
    case (state_r)
      ST_M1: begin mul_a = MUL_W'(nxn_r); mul_b = $signed({15'b0, h_eff}); end
      ST_M2: begin mul_a = MUL_W'(nyn_r); mul_b = $signed({15'b0, w_eff}); end
      ST_M3: begin mul_a = $signed({15'b0, w_eff}); mul_b = $signed({15'b0, h_eff}); end
      ST_M4: begin mul_a = MUL_W'(a_r); mul_b = MUL_W'(a_r); mop = M_LOAD; end
      ST_M5: begin mul_a = MUL_W'(b_r); mul_b = MUL_W'(b_r); mop = M_ADD; end
      ST_M6: begin mul_a = $signed({2'b0, wh_r}); mul_b = $signed({2'b0, wh_r}); end
      ST_Q1: begin mul_a = sx16(nx_r); mul_b = sx16(nx_r); mop = M_LOAD; end
      ST_Q2: begin mul_a = sx16(ny_r); mul_b = sx16(ny_r); mop = M_ADD; end
      ST_O1: begin
        mul_a = $signed({7'b0, ma_r[19:0]}); mul_b = $signed({7'b0, ma_r[19:0]}); mop = M_LOAD;
      end
      ST_O2: begin
        mul_a = $signed({7'b0, mb_r[19:0]}); mul_b = $signed({7'b0, mb_r[19:0]}); mop = M_ADD;
      end
      ST_D1: begin mul_a = sx16(l_r[0]); mul_b = sx16(c_r[0]); mop = M_LOAD; end
      ST_D2: begin mul_a = sx16(l_r[1]); mul_b = sx16(c_r[1]); mop = M_ADD; end
      ST_D3: begin mul_a = sx16(l_r[2]); mul_b = sx16(c_r[2]); mop = M_ADD; end
      ST_X1: begin mul_a = sx16(l_r[1]); mul_b = sx16(c_r[2]); mop = M_LOAD; end
      ST_X2: begin mul_a = sx16(l_r[2]); mul_b = sx16(c_r[1]); mop = M_SUB; end
      ST_Y1: begin mul_a = sx16(l_r[2]); mul_b = sx16(c_r[0]); mop = M_LOAD; end
      ST_Y2: begin mul_a = sx16(l_r[0]); mul_b = sx16(c_r[2]); mop = M_SUB; end
      ST_Z1: begin mul_a = sx16(l_r[0]); mul_b = sx16(c_r[1]); mop = M_LOAD; end
      ST_Z2: begin mul_a = sx16(l_r[1]); mul_b = sx16(c_r[0]); mop = M_SUB; end
      ST_L1: begin mul_a = sx16(d_r[1]); mul_b = sx16(d_r[1]); mop = M_LOAD; end
      ST_L2: begin mul_a = sx16(d_r[2]); mul_b = sx16(d_r[2]); mop = M_ADD; end
      ST_L3: begin mul_a = sx16(d_r[3]); mul_b = sx16(d_r[3]); mop = M_ADD; end
      ST_QP: begin
        mul_a = sx16(d_r[QP_DI[qp_cnt_r]]);
        mul_b = sx16(q_r[QP_QI[qp_cnt_r]]);
        mop   = QP_OP[qp_cnt_r];
      end
      default: mop = M_NONE;
    endcase
  end

  // registered product and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mop_r <= M_NONE;
    end else begin
      prod_r <= mul_a * mul_b;
      mop_r  <= mop;
      case (mop_r)
        M_LOAD:  acc_r <= ACC_W'(prod_r);
        M_ADD:   acc_r <= acc_r + ACC_W'(prod_r);
        M_SUB:   acc_r <= acc_r - ACC_W'(prod_r);
        default: acc_r <= acc_r;
      endcase
    end
  end

  // divide / square root requests
  always_comb begin
    isu_ctl.start = 1'b0;
    isu_ctl.op    = ISU_DIV;
    isu_num       = '0;
    isu_den       = '0;
    case (state_r)
      ST_NXS: begin
        isu_ctl.start = 1'b1;
        isu_num = ISU_NUM_W'({nxn_mag[12:0], 15'b0}) + ISU_NUM_W'(w_eff);
        isu_den = ISU_DEN_W'({w_eff, 1'b0});
      end
      ST_NYS: begin
        isu_ctl.start = 1'b1;
        isu_num = ISU_NUM_W'({nyn_mag[12:0], 15'b0}) + ISU_NUM_W'(h_eff);
        isu_den = ISU_DEN_W'({h_eff, 1'b0});
      end
      ST_ZS: begin
        isu_ctl.start = 1'b1;
        isu_ctl.op    = ISU_SQRT;
        isu_num       = zv[ACC_W-1] ? '0 : ISU_NUM_W'(zv[28:0]);
      end
      ST_OSQ: begin
        isu_ctl.start = 1'b1;
        isu_ctl.op    = ISU_SQRT;
        isu_num       = ISU_NUM_W'({acc_r[40:0], 16'b0});
      end
      ST_MXS: begin
        isu_ctl.start = 1'b1;
        isu_num = ISU_NUM_W'({ma_r[19:0], 23'b0}) + ISU_NUM_W'(len_r);
        isu_den = ISU_DEN_W'({len_r, 1'b0});
      end
      ST_MYS: begin
        isu_ctl.start = 1'b1;
        isu_num = ISU_NUM_W'({mb_r[19:0], 23'b0}) + ISU_NUM_W'(len_r);
        isu_den = ISU_DEN_W'({len_r, 1'b0});
      end
      default: isu_ctl.start = 1'b0;
    endcase
  end

  aqt_isu u_isu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (isu_ctl),
    .num   (isu_num),
    .den   (isu_den),
    .sts   (isu_sts),
    .res   (isu_res),
    .rem   (isu_rem)
  );

  // event sequencer, state and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_w_r     <= WIDTH_RST;
      cfg_h_r     <= HEIGHT_RST;
      drag_r      <= 1'b0;
      l_r         <= '0;
      q_r         <= {FW'(0), FW'(0), FW'(0), ONE_FW};
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_WIDTH) cfg_w_r <= cfg_wdata;
        else cfg_h_r <= cfg_wdata;
      end
      // result word taken; a reload in ST_DONE covers the same cycle
      if (out_valid_r && out_ready && state_r != ST_DONE) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            nxn_r <= nxn_in;
            nyn_r <= nyn_in;
            if (in_action == ACT_PRESS && in_button == BTN_LEFT) begin
              drag_r  <= 1'b1;
              press_r <= 1'b1;
              state_r <= ST_M1;
            end else if (in_action == ACT_RELEASE && in_button == BTN_LEFT) begin
              drag_r  <= 1'b0;
              state_r <= ST_DONE;
            end else if (in_action == ACT_MOVE && drag_r) begin
              press_r <= 1'b0;
              state_r <= ST_M1;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        // scaled coordinates and disk test
        ST_M1: state_r <= ST_M2;
        ST_M2: begin a_r <= prod_r[25:0]; state_r <= ST_M3; end
        ST_M3: begin b_r <= prod_r[25:0]; state_r <= ST_M4; end
        ST_M4: begin wh_r <= prod_r[24:0]; state_r <= ST_M5; end
        ST_M5: state_r <= ST_M6;
        ST_M6: state_r <= ST_CMP;
        ST_CMP: begin
          ma_r <= a_r[25] ? 26'(-a_r) : 26'(a_r);
          mb_r <= b_r[25] ? 26'(-b_r) : 26'(b_r);
          state_r <= (acc_r <= ACC_W'(prod_r)) ? ST_NXS : ST_NORM;
        end
        // inside the disk
        ST_NXS: state_r <= ST_NXW;
        ST_NXW: begin
          if (isu_sts.done) begin
            nx_r    <= sgn_sat(isu_res[QUO_W-1:0], nxn_r[13]);
            state_r <= ST_NYS;
          end
        end
        ST_NYS: state_r <= ST_NYW;
        ST_NYW: begin
          if (isu_sts.done) begin
            ny_r    <= sgn_sat(isu_res[QUO_W-1:0], nyn_r[13]);
            state_r <= ST_Q1;
          end
        end
        ST_Q1: state_r <= ST_Q2;
        ST_Q2: state_r <= ST_Q3;
        ST_Q3: state_r <= ST_ZS;
        ST_ZS: state_r <= ST_ZW;
        ST_ZW: begin
          if (isu_sts.done) begin
            c_r     <= {sgn_sat(zr, 1'b0), ny_r, nx_r};
            state_r <= ST_PT;
          end
        end
        // outside the disk: bring both magnitudes under 2^20
        ST_NORM: begin
          if ((|ma_r[25:20]) || (|mb_r[25:20])) begin
            ma_r <= ma_r >> 1;
            mb_r <= mb_r >> 1;
          end else begin
            state_r <= ST_O1;
          end
        end
        ST_O1: state_r <= ST_O2;
        ST_O2: state_r <= ST_O3;
        ST_O3: state_r <= ST_OSQ;
        ST_OSQ: state_r <= ST_OSQW;
        ST_OSQW: begin
          if (isu_sts.done) begin
            len_r   <= isu_res;
            state_r <= ST_MXS;
          end
        end
        ST_MXS: state_r <= ST_MXW;
        ST_MXW: begin
          if (isu_sts.done) begin
            c_r[0]  <= sgn_sat(isu_res[QUO_W-1:0], a_r[25]);
            state_r <= ST_MYS;
          end
        end
        ST_MYS: state_r <= ST_MYW;
        ST_MYW: begin
          if (isu_sts.done) begin
            c_r[1]  <= sgn_sat(isu_res[QUO_W-1:0], b_r[25]);
            c_r[2]  <= '0;
            state_r <= ST_PT;
          end
        end
        ST_PT: begin
          if (press_r) begin
            l_r     <= c_r;
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_D1;
          end
        end
        // delta quaternion: dot then cross
        ST_D1: state_r <= ST_D2;
        ST_D2: state_r <= ST_D3;
        ST_D3: state_r <= ST_X1;
        ST_X1: state_r <= ST_X2;
        ST_X2: begin
          if (rnd > ONE_ACC) d_r[0] <= ONE_FW;
          else if (rnd < -ONE_ACC) d_r[0] <= FW'(-ONE_ACC);
          else d_r[0] <= rnd[FW-1:0];
          state_r <= ST_Y1;
        end
        ST_Y1: state_r <= ST_Y2;
        ST_Y2: begin d_r[1] <= sat16(rnd); state_r <= ST_Z1; end
        ST_Z1: state_r <= ST_Z2;
        ST_Z2: begin d_r[2] <= sat16(rnd); state_r <= ST_L1; end
        ST_L1: state_r <= ST_L2;
        ST_L2: begin d_r[3] <= sat16(rnd); state_r <= ST_L3; end
        ST_L3: begin qp_cnt_r <= '0; state_r <= ST_QP; end
        // hamilton product, one term a cycle
        ST_QP: begin
          case (qp_cnt_r)
            4'd1:    len2_r <= acc_r[31:0];
            4'd5:    n_r[0] <= sat16(rnd);
            4'd9:    n_r[1] <= sat16(rnd);
            4'd13:   n_r[2] <= sat16(rnd);
            default: len2_r <= len2_r;
          endcase
          qp_cnt_r <= qp_cnt_r + 4'd1;
          if (qp_cnt_r == 4'd15) state_r <= ST_F1;
        end
        ST_F1: state_r <= ST_COMMIT;
        ST_COMMIT: begin
          if (len2_r > 32'(SMALL_AXIS_LIM)) q_r <= {sat16(rnd), n_r[2], n_r[1], n_r[0]};
          l_r     <= c_r;
          state_r <= ST_DONE;
        end
        // hand the result word to the output register
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_q_r     <= q_r;
            out_drag_r  <= drag_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_orient_w    = $signed(out_q_r[0]);
  assign out_orient_x    = $signed(out_q_r[1]);
  assign out_orient_y    = $signed(out_q_r[2]);
  assign out_orient_z    = $signed(out_q_r[3]);
  assign out_is_dragging = out_drag_r;

  // checks
  `AQT_ASSERT_IMP(a_isu_free, isu_ctl.start, !isu_sts.busy, "shared unit started while busy")
  `AQT_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "word taken while working")
  `AQT_ASSERT_NXT(a_orient_commit, rst_n && state_r != ST_COMMIT, $stable(q_r), "orientation moved outside commit")
  `AQT_ASSERT_NXT(a_result_loaded, state_r == ST_DONE && !out_valid_r, out_valid_r, "result word not loaded")

endmodule

// ===== rtl/aqt_isu.sv =====
// ---------------------------------------------------------------------------
// aqt_isu
// shared restoring divider and digit-by-digit square root, one bit a cycle
// ---------------------------------------------------------------------------
module aqt_isu import aqt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  isu_ctl_t             ctl,
  input  logic [ISU_NUM_W-1:0] num,
  input  logic [ISU_DEN_W-1:0] den,
  output isu_sts_t             sts,
  output logic [ISU_RES_W-1:0] res,
  output logic [ISU_REM_W-1:0] rem
);

  typedef enum logic {U_IDLE, U_RUN} ustate_t;

  ustate_t              ustate_r;
  isu_op_t              op_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 done_r;
  logic [ISU_REM_W-1:0] rem_r;
  logic [ISU_REM_W-1:0] dsh_r;
  logic [ISU_NUM_W-1:0] rad_r;
  logic [ISU_RES_W-1:0] res_r;
  logic [ISU_REM_W-1:0] opa;
  logic [ISU_REM_W-1:0] opb;
  logic [ISU_REM_W:0]   diff;
  logic                 ge;

  // one subtractor serves both operations
  always_comb begin
    if (op_r == ISU_DIV) begin
      opa = rem_r;
      opb = dsh_r;
    end else begin
      opa = {rem_r[ISU_REM_W-3:0], rad_r[ISU_NUM_W-1 -: 2]};
      opb = ISU_REM_W'({res_r, 2'b01});
    end
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = !diff[ISU_REM_W];
  end

  // sequencer and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ustate_r <= U_IDLE;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ustate_r)
        U_IDLE: begin
          if (ctl.start) begin
            op_r     <= ctl.op;
            res_r    <= '0;
            rad_r    <= num;
            dsh_r    <= ISU_REM_W'(den) << (DIV_STEPS - 1);
            rem_r    <= (ctl.op == ISU_DIV) ? ISU_REM_W'(num) : '0;
            cnt_r    <= (ctl.op == ISU_DIV) ? CNT_W'(DIV_STEPS - 1) : CNT_W'(SQRT_STEPS - 1);
            ustate_r <= U_RUN;
          end
        end
        U_RUN: begin
          rem_r <= ge ? diff[ISU_REM_W-1:0] : opa;
          res_r <= {res_r[ISU_RES_W-2:0], ge};
          rad_r <= rad_r << 2;
          dsh_r <= dsh_r >> 1;
          if (cnt_r == '0) begin
            done_r   <= 1'b1;
            ustate_r <= U_IDLE;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        default: ustate_r <= U_IDLE;
      endcase
    end
  end

  assign sts.busy = (ustate_r == U_RUN);
  assign sts.done = done_r;
  assign res      = res_r;
  assign rem      = rem_r;

endmodule
